[design/sacache_pkg.sv]
`timescale 1ns / 1ps

package sacache_pkg;

  localparam int CNT_W    = 32;
  localparam int CMD_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 6;

  // commands
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STORE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd2;
  localparam logic [CMD_W-1:0] CMD_IFETCH = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET   = 2'd2;

  // result word: 4 flags and three totals, padded to whole bytes
  localparam int OUT_W = ((4 + 3 * CNT_W + 7) / 8) * 8;

  typedef logic [CNT_W-1:0] cnt_t;

  function automatic cnt_t sat_inc(input cnt_t v);
    cnt_t r;
    r = (v == {CNT_W{1'b1}}) ? v : v + cnt_t'(1);
    return r;
  endfunction

endpackage

[design/set_assoc_cache_lru_tag_store_unit.sv]
// Tag store of a set-associative cache with LRU replacement. Each data access
// (load, store, modify) first reads the set's row from the tag memory, then
// compares the active ways, picks the victim and writes the row back; an
// instruction fetch gives no result word. All ways of a set live in one memory
// row, so the single memory port sets the rate. Lines start invalid through
// one flip-flop per set that marks rows written since reset, so there is no
// clearing pass. The three totals saturate at all ones. The user must write
// configuration only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps

module set_assoc_cache_lru_tag_store_unit #(
  parameter int MAX_SET_BITS = 8,
  parameter int NUM_WAYS     = 8,
  parameter int ADDR_WIDTH   = 64,
  localparam int IN_W = ((sacache_pkg::CMD_W + ADDR_WIDTH + 7) / 8) * 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [IN_W-1:0]                      in_tdata,   // cmd, address
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // was_hit, was_miss, did_evict, extra_hit, hit_total, miss_total, evict_total
  output logic [sacache_pkg::OUT_W-1:0]        out_tdata,
  input  logic                                 cfg_we,
  input  logic [sacache_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sacache_pkg::CFG_DAT_W-1:0]    cfg_wdata
);

  import sacache_pkg::*;

  localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int NUM_ROWS = 1 << MAX_SET_BITS;
  localparam int WAY_W    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int WC_W     = $clog2(NUM_WAYS + 1);
  localparam int RK_W     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int ORK_W    = RK_W + 1;
  localparam int SB_W     = $clog2(SET_W + 1);
  localparam logic [RK_W-1:0] RK_MAX = RK_W'(NUM_WAYS - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOOK = 1'b1;

  // configuration
  logic [3:0] cfg_sets_r, cfg_ways_r;
  logic [5:0] cfg_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_sets_r <= 4'd4;
      cfg_ways_r <= 4'd1;
      cfg_off_r  <= 6'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SET_BITS: cfg_sets_r <= cfg_wdata[3:0];
        REG_WAYS:     cfg_ways_r <= cfg_wdata[3:0];
        REG_OFFSET:   cfg_off_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [SB_W-1:0] sbits;
  logic [WC_W-1:0] ways;

  always_comb begin
    if (int'(cfg_sets_r) > MAX_SET_BITS) sbits = SB_W'(MAX_SET_BITS);
    else                                 sbits = SB_W'(cfg_sets_r);
    if (cfg_ways_r == 4'd0)                 ways = WC_W'(1);
    else if (int'(cfg_ways_r) > NUM_WAYS)   ways = WC_W'(NUM_WAYS);
    else                                    ways = WC_W'(cfg_ways_r);
  end

  // input decode
  logic [CMD_W-1:0]      in_cmd;
  logic [ADDR_WIDTH-1:0] in_addr, blk, in_tag;
  logic [SET_W-1:0]      set_mask, in_set;

  assign in_cmd   = in_tdata[CMD_W-1:0];
  assign in_addr  = in_tdata[CMD_W +: ADDR_WIDTH];
  assign blk      = in_addr >> cfg_off_r;
  assign set_mask = ~({SET_W{1'b1}} << sbits);
  assign in_set   = blk[SET_W-1:0] & set_mask;
  assign in_tag   = blk >> sbits;

  // control
  logic             state_r, state_nxt;
  logic             out_valid_r;
  logic             in_acc, start;
  logic [CMD_W-1:0] cmd_r;
  logic [SET_W-1:0] set_r;
  logic [ADDR_WIDTH-1:0] tag_r;
  logic [NUM_ROWS-1:0]   row_ok_r;
  logic                  row_hit_r;

  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign start     = in_acc && (in_cmd != CMD_IFETCH);
  assign state_nxt = start ? ST_LOOK : ST_IDLE;

  // tag memory: one row per set holding every way
  logic [NUM_WAYS-1:0]                 mem_valid [NUM_ROWS];
  logic [NUM_WAYS-1:0][ADDR_WIDTH-1:0] mem_tag   [NUM_ROWS];
  logic [NUM_WAYS-1:0][RK_W-1:0]       mem_rank  [NUM_ROWS];

  logic [NUM_WAYS-1:0]                 rd_valid_r;
  logic [NUM_WAYS-1:0][ADDR_WIDTH-1:0] rd_tag_r;
  logic [NUM_WAYS-1:0][RK_W-1:0]       rd_rank_r;

  logic [NUM_WAYS-1:0]                 nv;
  logic [NUM_WAYS-1:0][ADDR_WIDTH-1:0] nt;
  logic [NUM_WAYS-1:0][RK_W-1:0]       nr;

  always_ff @(posedge clk) begin
    if (start) begin
      rd_valid_r <= mem_valid[in_set];
      rd_tag_r   <= mem_tag[in_set];
      rd_rank_r  <= mem_rank[in_set];
    end
    if (state_r == ST_LOOK) begin
      mem_valid[set_r] <= nv;
      mem_tag[set_r]   <= nt;
      mem_rank[set_r]  <= nr;
    end
  end

  // compare, victim choice and row update
  logic [NUM_WAYS-1:0]           act, ev_valid, hitv;
  logic [NUM_WAYS-1:0][RK_W-1:0] ev_rank;
  logic                          hit, have_inv;
  logic [WAY_W-1:0]              hit_way, inv_way, vic, hot;
  logic [RK_W-1:0]               best_rk;
  logic [ORK_W-1:0]              old_rk;

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      act[w]      = (w < int'(ways));
      ev_valid[w] = row_hit_r & rd_valid_r[w];
      ev_rank[w]  = row_hit_r ? rd_rank_r[w] : '0;
      hitv[w]     = act[w] & ev_valid[w] & (rd_tag_r[w] == tag_r);
    end
    hit      = |hitv;
    have_inv = |(act & ~ev_valid);
    hit_way  = '0;
    inv_way  = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (hitv[w])                 hit_way = WAY_W'(w);
      if (act[w] && !ev_valid[w])  inv_way = WAY_W'(w);
    end
    vic     = '0;
    best_rk = ev_rank[0];
    for (int w = 1; w < NUM_WAYS; w++) begin
      if (act[w] && ev_rank[w] > best_rk) begin
        vic     = WAY_W'(w);
        best_rk = ev_rank[w];
      end
    end
    if (hit) begin
      hot    = hit_way;
      old_rk = {1'b0, ev_rank[hit_way]};
    end else if (have_inv) begin
      hot    = inv_way;
      old_rk = ORK_W'(NUM_WAYS);
    end else begin
      hot    = vic;
      old_rk = {1'b0, best_rk};
    end
    nv = ev_valid;
    nt = rd_tag_r;
    nr = ev_rank;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (act[w] && ev_valid[w] && WAY_W'(w) != hot &&
          {1'b0, ev_rank[w]} < old_rk && ev_rank[w] < RK_MAX)
        nr[w] = ev_rank[w] + RK_W'(1);
    end
    nr[hot] = '0;
    if (!hit) begin
      nv[hot] = 1'b1;
      nt[hot] = tag_r;
    end
  end

  // totals and result word
  cnt_t hit_cnt_r, miss_cnt_r, ev_cnt_r;
  cnt_t hit_cnt_nxt, miss_cnt_nxt, ev_cnt_nxt;
  logic evict;
  logic o_hit_r, o_miss_r, o_evict_r, o_extra_r;
  cnt_t o_hit_tot_r, o_miss_tot_r, o_ev_tot_r;

  always_comb begin
    evict        = !hit && !have_inv;
    hit_cnt_nxt  = hit ? sat_inc(hit_cnt_r) : hit_cnt_r;
    if (cmd_r == CMD_MODIFY) hit_cnt_nxt = sat_inc(hit_cnt_nxt);
    miss_cnt_nxt = hit ? miss_cnt_r : sat_inc(miss_cnt_r);
    ev_cnt_nxt   = evict ? sat_inc(ev_cnt_r) : ev_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      row_ok_r    <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      ev_cnt_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_LOOK) begin
        out_valid_r     <= 1'b1;
        row_ok_r[set_r] <= 1'b1;
        hit_cnt_r       <= hit_cnt_nxt;
        miss_cnt_r      <= miss_cnt_nxt;
        ev_cnt_r        <= ev_cnt_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cmd_r     <= in_cmd;
      set_r     <= in_set;
      tag_r     <= in_tag;
      row_hit_r <= row_ok_r[in_set];
    end
    if (state_r == ST_LOOK) begin
      o_hit_r      <= hit;
      o_miss_r     <= !hit;
      o_evict_r    <= evict;
      o_extra_r    <= (cmd_r == CMD_MODIFY);
      o_hit_tot_r  <= hit_cnt_nxt;
      o_miss_tot_r <= miss_cnt_nxt;
      o_ev_tot_r   <= ev_cnt_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W - 4 - 3 * CNT_W){1'b0}}, o_ev_tot_r, o_miss_tot_r,
                       o_hit_tot_r, o_extra_r, o_evict_r, o_miss_r, o_hit_r};

  // checks
  a_look_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOOK |-> $past(in_tvalid && in_tready && in_cmd != CMD_IFETCH))
    else $error("lookup without an accepted data access");

  a_result_from_look: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_LOOK))
    else $error("result word without a lookup");

  a_no_accept_in_look: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOOK |-> !in_tready)
    else $error("input taken during lookup");

  a_hit_total_grows: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> hit_cnt_r >= $past(hit_cnt_r))
    else $error("hit total went down");

endmodule

[verif/set_assoc_cache_lru_tag_store_checker.sv]
`timescale 1ns / 1ps

module cache_lru_checker #(
  parameter int MAX_SET_BITS = 8,
  parameter int NUM_WAYS     = 8,
  parameter int ADDR_WIDTH   = 64,
  parameter int IN_W         = 72
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [IN_W-1:0]                   in_tdata,   // cmd, address
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  // was_hit, was_miss, did_evict, extra_hit, hit_total, miss_total, evict_total
  input  logic [sacache_pkg::OUT_W-1:0]     out_tdata,
  input  logic                              cfg_we,
  input  logic [sacache_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sacache_pkg::CFG_DAT_W-1:0] cfg_wdata,
  output int                                mismatches,
  output int                                pending
);
  import sacache_pkg::*;

  localparam int LINES = (1 << MAX_SET_BITS) * NUM_WAYS;

  typedef struct packed {
    cnt_t evict_total;
    cnt_t miss_total;
    cnt_t hit_total;
    logic extra_hit;
    logic did_evict;
    logic was_miss;
    logic was_hit;
  } access_result_t;

  logic        line_ok  [LINES];
  logic [63:0] line_tag [LINES];
  int          line_age [LINES];
  logic [3:0]  set_bits_reg;
  logic [3:0]  ways_reg;
  logic [5:0]  offset_reg;
  cnt_t        hits;
  cnt_t        misses;
  cnt_t        evictions;

  access_result_t expected_results[$];

  function automatic cnt_t bump(input cnt_t v);
    return (v == '1) ? v : v + cnt_t'(1);
  endfunction

  // make way hot the youngest; valid ways younger than its old age grow older
  function automatic void age_promote(input int base, input int ways, input int hot,
                                      input int old_age);
    int w;
    for (w = 0; w < ways; w++) begin
      if (w != hot && line_ok[base + w] && line_age[base + w] < old_age &&
          line_age[base + w] < NUM_WAYS - 1)
        line_age[base + w]++;
    end
    line_age[base + hot] = 0;
  endfunction

  function automatic access_result_t cache_access(input logic [CMD_W-1:0] cmd,
                                                  input logic [63:0] addr);
    access_result_t r;
    int sb, ways, set_no, base, victim, w;
    logic [63:0] blk, tag;
    logic hit, free_way;
    sb = (set_bits_reg > MAX_SET_BITS) ? MAX_SET_BITS : int'(set_bits_reg);
    ways = (ways_reg == 0) ? 1 : ((ways_reg > NUM_WAYS) ? NUM_WAYS : int'(ways_reg));
    blk = addr >> offset_reg;
    set_no = int'(blk & ((64'd1 << sb) - 64'd1));
    tag = blk >> sb;
    base = set_no * NUM_WAYS;
    hit = 1'b0;
    free_way = 1'b0;
    victim = 0;
    r = '0;
    for (w = 0; w < ways; w++) begin
      if (!hit && line_ok[base + w] && line_tag[base + w] == tag) begin
        hit = 1'b1;
        victim = w;
      end
    end
    if (hit) begin
      hits = bump(hits);
      age_promote(base, ways, victim, line_age[base + victim]);
    end else begin
      for (w = 0; w < ways; w++) begin
        if (!free_way && !line_ok[base + w]) begin
          free_way = 1'b1;
          victim = w;
        end
      end
      if (!free_way) begin
        victim = 0;
        for (w = 1; w < ways; w++) begin
          if (line_age[base + w] > line_age[base + victim]) victim = w;
        end
        evictions = bump(evictions);
        r.did_evict = 1'b1;
      end
      misses = bump(misses);
      age_promote(base, ways, victim, free_way ? NUM_WAYS : line_age[base + victim]);
      line_ok[base + victim] = 1'b1;
      line_tag[base + victim] = tag;
    end
    if (cmd == CMD_MODIFY) hits = bump(hits);
    r.was_hit = hit;
    r.was_miss = !hit;
    r.extra_hit = (cmd == CMD_MODIFY);
    r.hit_total = hits;
    r.miss_total = misses;
    r.evict_total = evictions;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    access_result_t want, got;
    int i;
    if (!rst_n) begin
      for (i = 0; i < LINES; i++) begin
        line_ok[i] = 1'b0;
        line_tag[i] = '0;
        line_age[i] = 0;
      end
      set_bits_reg = 4'd4;
      ways_reg = 4'd1;
      offset_reg = 6'd4;
      hits = '0;
      misses = '0;
      evictions = '0;
      expected_results.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SET_BITS: set_bits_reg = cfg_wdata[3:0];
          REG_WAYS:     ways_reg = cfg_wdata[3:0];
          REG_OFFSET:   offset_reg = cfg_wdata[5:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready && in_tdata[CMD_W-1:0] != CMD_IFETCH)
        expected_results.push_back(cache_access(in_tdata[CMD_W-1:0],
                                                64'(in_tdata[CMD_W +: ADDR_WIDTH])));
      if (out_tvalid && out_tready) begin
        got = access_result_t'(out_tdata[$bits(access_result_t)-1:0]);
        if (expected_results.size() == 0) begin
          $display("%0t: word with nothing expected, expected none actual %h",
                   $time, out_tdata);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("was_hit", 64'(want.was_hit), 64'(got.was_hit));
          check_field("was_miss", 64'(want.was_miss), 64'(got.was_miss));
          check_field("did_evict", 64'(want.did_evict), 64'(got.did_evict));
          check_field("extra_hit", 64'(want.extra_hit), 64'(got.extra_hit));
          check_field("hit_total", 64'(want.hit_total), 64'(got.hit_total));
          check_field("miss_total", 64'(want.miss_total), 64'(got.miss_total));
          check_field("evict_total", 64'(want.evict_total), 64'(got.evict_total));
          check_field("padding", 64'd0,
                      64'(out_tdata[OUT_W-1:$bits(access_result_t)]));
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
  import sacache_pkg::*;

  localparam int MAX_SET_BITS = 8;
  localparam int NUM_WAYS     = 8;
  localparam int ADDR_WIDTH   = 64;
  localparam int IN_W         = ((CMD_W + ADDR_WIDTH + 7) / 8) * 8;
  localparam int PAD_W        = IN_W - CMD_W - ADDR_WIDTH;
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata = '0;   // cmd, address
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  // was_hit, was_miss, did_evict, extra_hit, hit_total, miss_total, evict_total
  logic [OUT_W-1:0]     out_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SET_BITS;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  int          mismatches;
  int          pending;
  int          quiet_cycles = 0;
  bit          tx_gaps = 1'b1;
  bit          rx_stalls = 1'b1;
  bit          hold_off = 1'b0;
  int          cur_sbits = 4;
  int          cur_ways = 1;
  int          cur_offs = 4;
  int          pool_size = 3;
  logic [63:0] tag_pool [10];

  set_assoc_cache_lru_tag_store_unit #(
    .MAX_SET_BITS(MAX_SET_BITS),
    .NUM_WAYS    (NUM_WAYS),
    .ADDR_WIDTH  (ADDR_WIDTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  cache_lru_checker #(
    .MAX_SET_BITS(MAX_SET_BITS),
    .NUM_WAYS    (NUM_WAYS),
    .ADDR_WIDTH  (ADDR_WIDTH),
    .IN_W        (IN_W)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .mismatches(mismatches),
    .pending   (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [63:0] addr);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{PAD_W{1'b0}}, addr[ADDR_WIDTH-1:0], cmd};
    do @(posedge clk); while (!in_tready);
  endtask

  // stop offering, wait until every word is back, then idle
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_cache(input int sbits, input int ways, input int offs);
    cfg_we <= 1'b1;
    cfg_index <= REG_SET_BITS;
    cfg_wdata <= CFG_DAT_W'(sbits);
    @(posedge clk);
    cfg_index <= REG_WAYS;
    cfg_wdata <= CFG_DAT_W'(ways);
    @(posedge clk);
    cfg_index <= REG_OFFSET;
    cfg_wdata <= CFG_DAT_W'(offs);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_sbits = sbits;
    cur_ways = ways;
    cur_offs = offs;
  endtask

  function automatic logic [CMD_W-1:0] pick_cmd();
    int r;
    r = $urandom_range(0, 11);
    if (r == 0) return CMD_IFETCH;
    else if (r < 5) return CMD_LOAD;
    else if (r < 8) return CMD_STORE;
    else return CMD_MODIFY;
  endfunction

  // mostly a small pool of tags over a few sets, so hits and evictions both happen
  function automatic logic [63:0] pick_addr();
    int sb;
    logic [63:0] tag, set_no, low;
    sb = (cur_sbits > MAX_SET_BITS) ? MAX_SET_BITS : cur_sbits;
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    tag = tag_pool[$urandom_range(0, pool_size - 1)];
    set_no = 64'($urandom_range(0, 3)) & ((64'd1 << sb) - 64'd1);
    low = {$urandom, $urandom} & ((64'd1 << cur_offs) - 64'd1);
    return (tag << (sb + cur_offs)) | (set_no << cur_offs) | low;
  endfunction

  initial begin : receiver
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end else begin
        stall = rx_stalls ? $urandom_range(0, 7) : 0;
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin : stimulus
    int phase, t, ways_eff;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset setting: 16 sets, direct mapped, 16-byte lines
    send_word(CMD_LOAD, 64'h0);
    send_word(CMD_LOAD, 64'h0);
    send_word(CMD_STORE, 64'hF);
    send_word(CMD_MODIFY, 64'h0);
    send_word(CMD_IFETCH, 64'h100);
    send_word(CMD_LOAD, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(CMD_STORE, 64'h100);
    send_word(CMD_MODIFY, 64'h200);
    send_word(CMD_IFETCH, 64'hFFFF_FFFF_FFFF_FFFF);
    settle();

    // one fully associative set, lru order
    program_cache(0, 8, 0);
    for (t = 1; t <= 9; t++) send_word(CMD_LOAD, 64'(t));
    send_word(CMD_STORE, 64'h2);
    send_word(CMD_LOAD, 64'hA);
    send_word(CMD_MODIFY, 64'h3);
    settle();

    // register values beyond the built sizes
    program_cache(15, 15, 63);
    send_word(CMD_LOAD, 64'h0);
    send_word(CMD_STORE, 64'h8000_0000_0000_0000);
    send_word(CMD_MODIFY, 64'h7FFF_FFFF_FFFF_FFFF);
    settle();

    program_cache(8, 0, 32);
    send_word(CMD_LOAD, 64'h1234_5678_9ABC_DEF0);
    send_word(CMD_LOAD, 64'h1334_5678_0000_0000);

    for (phase = 0; phase < 10; phase++) begin
      settle();
      case (phase)
        0: program_cache(8, 8, 32);
        1: program_cache(0, 1, 0);
        2: program_cache(2, 4, 6);
        3: program_cache(15, 0, 63);
        default: program_cache($urandom_range(0, 15), $urandom_range(0, 15),
                               $urandom_range(0, 12));
      endcase
      tx_gaps = (phase % 3) != 1;
      rx_stalls = (phase % 3) != 2;
      if (phase == 4) begin
        tx_gaps = 1'b0;
        rx_stalls = 1'b0;
        hold_off = 1'b1;
      end
      ways_eff = (cur_ways == 0) ? 1 : ((cur_ways > NUM_WAYS) ? NUM_WAYS : cur_ways);
      pool_size = ways_eff + 2;
      for (t = 0; t < 10; t++) tag_pool[t] = {$urandom, $urandom};
      repeat (65) send_word(pick_cmd(), pick_addr());
    end
    settle();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
